// File: rtl/scc_pkg.sv
// Package for the strongly connected component labeler.
// Holds the port field widths, command codes, reset and sizing defaults
// and the result type. Depends on nothing.
package scc_pkg;

  localparam int PORT_W = 11;
  localparam int CMD_W  = 2;

  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_MAX_EDGES = 4096;

  localparam logic [PORT_W-1:0] NODE_COUNT_RESET = 11'd1024;

  localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

  typedef struct packed {
    logic [PORT_W-1:0] value;
    logic              edges_dropped;
  } scc_result_t;

endpackage

// File: rtl/scc_req_if.sv
// Request channel interface: command with source and target node.
// Depends on scc_pkg.
interface scc_req_if;
  logic                       valid;
  logic                       ready;
  logic [scc_pkg::CMD_W-1:0]  command;
  logic [scc_pkg::PORT_W-1:0] source_node;
  logic [scc_pkg::PORT_W-1:0] target_node;
  modport source (output valid, command, source_node, target_node, input ready);
  modport sink (input valid, command, source_node, target_node, output ready);
endinterface

// File: rtl/scc_rsp_if.sv
// Response channel interface: component count or node label.
// Depends on scc_pkg.
interface scc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [scc_pkg::PORT_W-1:0] value;
  logic                       edges_dropped;
  modport source (output valid, value, edges_dropped, input ready);
  modport sink (input valid, value, edges_dropped, output ready);
endinterface

// File: rtl/scc_cfg_if.sv
// Configuration write channel interface for the node count register.
// Depends on scc_pkg.
interface scc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [scc_pkg::PORT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/scc_engine.sv
// Graph store and Kosaraju sequencer: all lists, stacks, marks and labels
// live in synchronous memories with registered read data.
// Depends on scc_pkg.
module scc_engine #(
  parameter int MAX_NODES = scc_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = scc_pkg::DEF_MAX_EDGES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [$clog2(MAX_NODES+1)-1:0]   n,
  input  logic                             start,
  input  logic [scc_pkg::CMD_W-1:0]        command,
  input  logic [scc_pkg::PORT_W-1:0]       source_node,
  input  logic [scc_pkg::PORT_W-1:0]       target_node,
  output logic                             idle,
  output logic                             res_valid,
  input  logic                             res_ready,
  output scc_pkg::scc_result_t             res
);

  localparam int NAW = $clog2(MAX_NODES);
  localparam int NVW = $clog2(MAX_NODES + 1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int CW  = (NVW > scc_pkg::PORT_W) ? NVW : scc_pkg::PORT_W;
  localparam int SKW = NAW + EW;

  typedef enum logic [25:0] {
    ST_CLEAR    = 26'd1,
    ST_IDLE     = 26'd2,
    ST_ADD_WR   = 26'd4,
    ST_ADD_LINK = 26'd8,
    ST_QUERY    = 26'd16,
    ST_SWEEP    = 26'd32,
    P1_START    = 26'd64,
    P1_CHK      = 26'd128,
    P1_WALK     = 26'd256,
    P1_POP      = 26'd512,
    P1_EDGE     = 26'd1024,
    P1_VIS      = 26'd2048,
    R_START     = 26'd4096,
    R_HEAD      = 26'd8192,
    R_WALK      = 26'd16384,
    R_EDGE      = 26'd32768,
    R_LINK      = 26'd65536,
    S_START     = 26'd131072,
    S_FIN       = 26'd262144,
    S_CHK       = 26'd524288,
    S_HEAD      = 26'd1048576,
    S_WALK      = 26'd2097152,
    S_POP       = 26'd4194304,
    S_SRC       = 26'd8388608,
    S_VIS       = 26'd16777216,
    ST_DONE     = 26'd33554432
  } state_t;

  state_t state, state_next;

  logic [NAW-1:0] sw;
  logic           pass2;
  logic [NVW-1:0] cnt, scan, sp, fin, f;
  logic [EW-1:0]  ptr, total, k;
  logic [NAW-1:0] node, other;
  logic           flag, q_ok;

  logic [2*EW-1:0] out_mem [MAX_NODES];
  logic [NAW-1:0]  edge_dest [MAX_EDGES];
  logic [EW-1:0]   edge_next [MAX_EDGES];
  logic [2*EW-1:0] in_mem [MAX_NODES];
  logic [NAW-1:0]  in_src [MAX_EDGES];
  logic [EW-1:0]   in_next [MAX_EDGES];
  logic            visited [MAX_NODES];
  logic [NAW-1:0]  finish [MAX_NODES];
  logic [SKW-1:0]  stack [MAX_NODES];
  logic [NVW-1:0]  label [MAX_NODES];

  logic [2*EW-1:0] out_rd, out_wd, in_rd, in_wd;
  logic [NAW-1:0]  out_ra, out_wa, in_ra, in_wa, vis_ra, vis_wa, fin_ra, stk_ra, stk_wa;
  logic [NAW-1:0]  lab_ra, lab_wa;
  logic            out_we, in_we, vis_we, vis_wd, vis_rd, fin_we, stk_we, lab_we;
  logic [NAW-1:0]  dest_rd, dest_wd, src_rd, fin_rd;
  logic [EAW-1:0]  edge_ra, dest_wa, enext_wa, ins_ra, ins_wa, innx_wa;
  logic            dest_we, enext_we, ins_we, innx_we;
  logic [EW-1:0]   enext_rd, enext_wd, innx_rd, innx_wd;
  logic [SKW-1:0]  stk_rd, stk_wd;
  logic [NVW-1:0]  lab_rd, lab_wd;

  logic [CW-1:0]  s_ext, d_ext, n_ext, s_m1, d_m1;
  logic           s_ok, d_ok;
  logic [EW-1:0]  ptr_m1, in_tail_m1, total_p1, k_p1;
  logic [NVW-1:0] sp_m1, sp_m2, f_m1, fin_m1;
  logic           dest_ok, full;

  assign s_ext       = CW'(source_node);
  assign d_ext       = CW'(target_node);
  assign n_ext       = CW'(n);
  assign s_m1        = s_ext - CW'(1);
  assign d_m1        = d_ext - CW'(1);
  assign s_ok        = (s_ext != '0) && (s_ext <= n_ext);
  assign d_ok        = (d_ext != '0) && (d_ext <= n_ext);
  assign ptr_m1      = ptr - EW'(1);
  assign in_tail_m1  = in_rd[EW-1:0] - EW'(1);
  assign total_p1    = total + EW'(1);
  assign k_p1        = k + EW'(1);
  assign sp_m1       = sp - NVW'(1);
  assign sp_m2       = sp - NVW'(2);
  assign f_m1        = f - NVW'(1);
  assign fin_m1      = fin;
  assign dest_ok     = NVW'(dest_rd) < n;
  assign full        = total == EW'(MAX_EDGES);

  always_comb begin
    state_next = state;
    out_ra = '0; out_we = 1'b0; out_wa = node; out_wd = '0;
    in_ra = '0; in_we = 1'b0; in_wa = other; in_wd = '0;
    vis_ra = '0; vis_we = 1'b0; vis_wa = other; vis_wd = 1'b1;
    fin_ra = f_m1[NAW-1:0]; fin_we = 1'b0;
    stk_ra = '0; stk_we = 1'b0; stk_wa = sp[NAW-1:0]; stk_wd = '0;
    lab_ra = other; lab_we = 1'b0; lab_wa = other; lab_wd = cnt;
    edge_ra = ptr_m1[EAW-1:0]; ins_ra = ptr_m1[EAW-1:0];
    dest_we = 1'b0; dest_wa = total[EAW-1:0]; dest_wd = other;
    enext_we = 1'b0; enext_wa = total[EAW-1:0]; enext_wd = '0;
    ins_we = 1'b0; ins_wa = k[EAW-1:0];
    innx_we = 1'b0; innx_wa = k[EAW-1:0]; innx_wd = '0;
    case (state)
      ST_CLEAR: begin
        out_we = 1'b1; out_wa = sw;
        lab_we = 1'b1; lab_wa = sw; lab_wd = '0;
        if (sw == NAW'(MAX_NODES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        out_ra = s_m1[NAW-1:0];
        lab_ra = s_m1[NAW-1:0];
        if (start) begin
          case (command)
            scc_pkg::CMD_ADD: begin
              if (s_ok && d_ok && !full) state_next = ST_ADD_WR;
            end
            scc_pkg::CMD_COMPUTE: state_next = ST_SWEEP;
            scc_pkg::CMD_QUERY: state_next = ST_QUERY;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD_WR: begin
        out_we = 1'b1;
        out_wd = {(out_rd[EW-1:0] == '0) ? total_p1 : out_rd[2*EW-1:EW], total_p1};
        dest_we = 1'b1;
        enext_we = 1'b1;
        state_next = (out_rd[EW-1:0] != '0) ? ST_ADD_LINK : ST_IDLE;
      end
      ST_ADD_LINK: begin
        enext_we = 1'b1; enext_wa = ptr_m1[EAW-1:0]; enext_wd = total;
        state_next = ST_IDLE;
      end
      ST_QUERY: begin
        lab_ra = node;
        if (res_ready) state_next = ST_IDLE;
      end
      ST_SWEEP: begin
        vis_we = 1'b1; vis_wa = sw; vis_wd = 1'b0;
        if (!pass2) begin
          in_we = 1'b1; in_wa = sw;
          lab_we = 1'b1; lab_wa = sw; lab_wd = '0;
        end
        if (sw == NAW'(MAX_NODES - 1)) state_next = pass2 ? S_START : P1_START;
      end
      P1_START: begin
        vis_ra = scan[NAW-1:0];
        out_ra = scan[NAW-1:0];
        state_next = (scan >= n) ? R_START : P1_CHK;
      end
      P1_CHK: begin
        if (!vis_rd) begin
          vis_we = 1'b1; vis_wa = scan[NAW-1:0];
          state_next = P1_WALK;
        end else begin
          state_next = P1_START;
        end
      end
      P1_WALK: begin
        stk_ra = sp_m2[NAW-1:0];
        if (ptr == '0) begin
          fin_we = 1'b1;
          state_next = (sp == NVW'(1)) ? P1_START : P1_POP;
        end else begin
          state_next = P1_EDGE;
        end
      end
      P1_POP: state_next = P1_WALK;
      P1_EDGE: begin
        vis_ra = dest_rd;
        out_ra = dest_rd;
        state_next = dest_ok ? P1_VIS : P1_WALK;
      end
      P1_VIS: begin
        if (!vis_rd) begin
          vis_we = 1'b1;
          stk_we = 1'b1; stk_wa = sp_m1[NAW-1:0]; stk_wd = {node, ptr};
        end
        state_next = P1_WALK;
      end
      R_START: begin
        out_ra = scan[NAW-1:0];
        state_next = (scan >= n) ? ST_SWEEP : R_HEAD;
      end
      R_HEAD: state_next = R_WALK;
      R_WALK: state_next = (ptr == '0) ? R_START : R_EDGE;
      R_EDGE: begin
        in_ra = dest_rd;
        if (dest_ok) begin
          ins_we = 1'b1;
          innx_we = 1'b1;
          state_next = R_LINK;
        end else begin
          state_next = R_WALK;
        end
      end
      R_LINK: begin
        in_we = 1'b1;
        in_wd = {(in_rd[EW-1:0] == '0) ? k_p1 : in_rd[2*EW-1:EW], k_p1};
        if (in_rd[EW-1:0] != '0) begin
          innx_we = 1'b1; innx_wa = in_tail_m1[EAW-1:0]; innx_wd = k_p1;
        end
        state_next = R_WALK;
      end
      S_START: state_next = (f == '0) ? ST_DONE : S_FIN;
      S_FIN: begin
        vis_ra = fin_rd;
        state_next = S_CHK;
      end
      S_CHK: begin
        in_ra = other;
        if (!vis_rd) begin
          vis_we = 1'b1;
          lab_we = 1'b1; lab_wd = cnt + NVW'(1);
          state_next = S_HEAD;
        end else begin
          state_next = S_START;
        end
      end
      S_HEAD: state_next = S_WALK;
      S_WALK: begin
        stk_ra = sp_m1[NAW-1:0];
        if (ptr == '0) state_next = (sp == '0) ? S_START : S_POP;
        else state_next = S_SRC;
      end
      S_POP: begin
        in_ra = stk_rd[SKW-1:EW];
        state_next = S_HEAD;
      end
      S_SRC: begin
        vis_ra = src_rd;
        state_next = S_VIS;
      end
      S_VIS: begin
        if (!vis_rd) begin
          vis_we = 1'b1;
          lab_we = 1'b1;
          stk_we = 1'b1; stk_wd = {other, EW'(0)};
        end
        state_next = S_WALK;
      end
      ST_DONE: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_we) out_mem[out_wa] <= out_wd;
    out_rd <= out_mem[out_ra];
    if (in_we) in_mem[in_wa] <= in_wd;
    in_rd <= in_mem[in_ra];
    if (vis_we) visited[vis_wa] <= vis_wd;
    vis_rd <= visited[vis_ra];
    if (fin_we) finish[fin_m1[NAW-1:0]] <= node;
    fin_rd <= finish[fin_ra];
    if (stk_we) stack[stk_wa] <= stk_wd;
    stk_rd <= stack[stk_ra];
    if (lab_we) label[lab_wa] <= lab_wd;
    lab_rd <= label[lab_ra];
    if (dest_we) edge_dest[dest_wa] <= dest_wd;
    dest_rd <= edge_dest[edge_ra];
    if (enext_we) edge_next[enext_wa] <= enext_wd;
    enext_rd <= edge_next[edge_ra];
    if (ins_we) in_src[ins_wa] <= scan[NAW-1:0];
    src_rd <= in_src[ins_ra];
    if (innx_we) in_next[innx_wa] <= innx_wd;
    innx_rd <= in_next[ins_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      sw    <= '0;
      total <= '0;
      flag  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: sw <= sw + NAW'(1);
        ST_IDLE: begin
          node  <= s_m1[NAW-1:0];
          other <= d_m1[NAW-1:0];
          q_ok  <= s_ok;
          sw    <= '0;
          pass2 <= 1'b0;
          scan  <= '0;
          if (start && command == scc_pkg::CMD_ADD && s_ok && d_ok && full) flag <= 1'b1;
        end
        ST_ADD_WR: begin
          total <= total_p1;
          ptr   <= out_rd[EW-1:0];
        end
        ST_SWEEP: begin
          sw <= sw + NAW'(1);
          if (sw == NAW'(MAX_NODES - 1)) begin
            fin  <= '0;
            f    <= fin;
            cnt  <= '0;
            sp   <= '0;
            scan <= '0;
          end
        end
        P1_CHK: begin
          if (!vis_rd) begin
            node <= scan[NAW-1:0];
            ptr  <= out_rd[2*EW-1:EW];
            sp   <= NVW'(1);
          end else begin
            scan <= scan + NVW'(1);
          end
        end
        P1_START: begin
          if (scan >= n) begin
            scan <= '0;
            k    <= '0;
          end
        end
        P1_WALK: begin
          if (ptr == '0) begin
            fin <= fin + NVW'(1);
            sp  <= sp_m1;
            if (sp == NVW'(1)) scan <= scan + NVW'(1);
          end
        end
        P1_POP: {node, ptr} <= stk_rd;
        P1_EDGE: begin
          ptr   <= enext_rd;
          other <= dest_rd;
        end
        P1_VIS: begin
          if (!vis_rd) begin
            node <= other;
            ptr  <= out_rd[2*EW-1:EW];
            sp   <= sp + NVW'(1);
          end
        end
        R_START: begin
          if (scan >= n) begin
            sw    <= '0;
            pass2 <= 1'b1;
          end
        end
        R_HEAD: ptr <= out_rd[2*EW-1:EW];
        R_WALK: begin
          if (ptr == '0) scan <= scan + NVW'(1);
        end
        R_EDGE: begin
          ptr   <= enext_rd;
          other <= dest_rd;
        end
        R_LINK: k <= k_p1;
        S_FIN: other <= fin_rd;
        S_CHK: begin
          if (!vis_rd) cnt <= cnt + NVW'(1);
          else f <= f_m1;
        end
        S_HEAD: ptr <= in_rd[2*EW-1:EW];
        S_WALK: begin
          if (ptr == '0) begin
            if (sp == '0) f <= f_m1;
            else sp <= sp_m1;
          end
        end
        S_SRC: begin
          ptr   <= innx_rd;
          other <= src_rd;
        end
        S_VIS: begin
          if (!vis_rd) sp <= sp + NVW'(1);
        end
        default: ;
      endcase
    end
  end

  assign idle      = state == ST_IDLE;
  assign res_valid = (state == ST_DONE) || (state == ST_QUERY);
  assign res.edges_dropped = flag;
  assign res.value = (state == ST_DONE) ? scc_pkg::PORT_W'(cnt)
                   : (q_ok ? scc_pkg::PORT_W'(lab_rd) : '0);

endmodule

// File: rtl/strongly_connected_component_labeler_core.sv
// Top level of the strongly connected component labeler.
// Holds the node count register and the response register; depends on
// scc_pkg, the three channel interfaces and scc_engine.
//
//   channel  modport  payload                                  transfer
//   req      sink     command, source_node, target_node        valid & ready
//   rsp      source   value, edges_dropped                     valid & ready
//   cfg      sink     data (node_count)                        valid & ready
//
// After reset a clearing pass over all MAX_NODES entries runs before the
// first request is taken. An add edge request writes in ST_ADD_WR and, if
// the source already has edges, links in ST_ADD_LINK; an ignored or dropped
// one stores nothing. A query waits in ST_QUERY for the response register.
// A compute request runs two clearing sweeps over MAX_NODES entries and
// three walks over nodes and edges, paced by the single read port of each
// memory. A waiting response stalls only the next request that answers.
module strongly_connected_component_labeler_core #(
  parameter int MAX_NODES = scc_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = scc_pkg::DEF_MAX_EDGES
) (
  input logic       clk,
  input logic       rst,
  scc_req_if.sink   req,
  scc_rsp_if.source rsp,
  scc_cfg_if.sink   cfg
);

  localparam int NVW = $clog2(MAX_NODES + 1);
  localparam int CW  = (NVW > scc_pkg::PORT_W) ? NVW : scc_pkg::PORT_W;

  logic [scc_pkg::PORT_W-1:0] node_count;
  logic [CW-1:0]              count_ext;
  logic [NVW-1:0]             n;
  logic                       idle, res_valid, slot_free;
  scc_pkg::scc_result_t       res;

  assign count_ext = CW'(node_count);
  assign n = (count_ext > CW'(MAX_NODES)) ? NVW'(MAX_NODES) : NVW'(count_ext);
  assign cfg.ready = 1'b1;
  assign req.ready = idle;
  assign slot_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= scc_pkg::NODE_COUNT_RESET;
    end else if (cfg.valid) begin
      node_count <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_valid && slot_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (res_valid && slot_free) begin
      rsp.value         <= res.value;
      rsp.edges_dropped <= res.edges_dropped;
    end
  end

  scc_engine #(
    .MAX_NODES(MAX_NODES),
    .MAX_EDGES(MAX_EDGES)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .n          (n),
    .start      (req.valid && idle),
    .command    (req.command),
    .source_node(req.source_node),
    .target_node(req.target_node),
    .idle       (idle),
    .res_valid  (res_valid),
    .res_ready  (slot_free),
    .res        (res)
  );

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for strongly_connected_component_labeler_core.
// Depends on scc_pkg and the request, response and configuration interfaces.
// Holds a behavioral Kosaraju predictor, a directed table and random phases.
module tb;

  localparam logic [scc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int NMAX = scc_pkg::DEF_MAX_NODES;
  localparam int EMAX = scc_pkg::DEF_MAX_EDGES;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int RANDOM_ITEMS = 1700;
  localparam int NROWS = 28;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  cmd;
    int          src;
    int          dst;
    bit          typed;
    int          val;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  scc_req_if req ();
  scc_rsp_if rsp ();
  scc_cfg_if cfg ();

  strongly_connected_component_labeler_core dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Graph model state.
  int unsigned model_nodes;
  int unsigned head_o[NMAX+1], tail_o[NMAX+1], dst_e[EMAX], link_o[EMAX];
  int unsigned head_i[NMAX+1], tail_i[NMAX+1], src_i[EMAX], link_i[EMAX];
  bit          seen[NMAX+1];
  int unsigned fin_ord[NMAX], stk_n[NMAX], stk_p[NMAX], label[NMAX+1];
  int unsigned n_edges, n_comp;
  bit          dropped;

  scc_pkg::scc_result_t pending_rsp[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int items_sent = 0;
  int stall_mode = 0;

  row_t plan[NROWS] = '{
    '{0, scc_pkg::CMD_QUERY, 1, 0, 1, 0},
    '{0, scc_pkg::CMD_QUERY, 0, 0, 1, 0},
    '{0, scc_pkg::CMD_COMPUTE, 0, 0, 1, 1024},
    '{0, scc_pkg::CMD_QUERY, 1024, 0, 0, 0},
    '{1, scc_pkg::CMD_ADD, 4, 0, 0, 0},
    '{0, scc_pkg::CMD_ADD, 1, 2, 0, 0},
    '{0, scc_pkg::CMD_ADD, 2, 3, 0, 0},
    '{0, scc_pkg::CMD_ADD, 3, 1, 0, 0},
    '{0, scc_pkg::CMD_ADD, 3, 4, 0, 0},
    '{0, scc_pkg::CMD_ADD, 0, 1, 0, 0},
    '{0, scc_pkg::CMD_ADD, 5, 1, 0, 0},
    '{0, scc_pkg::CMD_ADD, 2047, 2047, 0, 0},
    '{0, scc_pkg::CMD_COMPUTE, 0, 0, 0, 0},
    '{0, scc_pkg::CMD_QUERY, 4, 0, 0, 0},
    '{0, scc_pkg::CMD_QUERY, 1, 0, 0, 0},
    '{0, scc_pkg::CMD_QUERY, 5, 0, 1, 0},
    '{0, scc_pkg::CMD_QUERY, 2047, 0, 1, 0},
    '{0, CMD_UNUSED, 2047, 2047, 0, 0},
    '{1, scc_pkg::CMD_ADD, 2047, 0, 0, 0},
    '{0, scc_pkg::CMD_COMPUTE, 0, 0, 0, 0},
    '{1, scc_pkg::CMD_ADD, 0, 0, 0, 0},
    '{0, scc_pkg::CMD_ADD, 1, 1, 0, 0},
    '{0, scc_pkg::CMD_COMPUTE, 0, 0, 1, 0},
    '{0, scc_pkg::CMD_QUERY, 1, 0, 1, 0},
    '{1, scc_pkg::CMD_ADD, 1, 0, 0, 0},
    '{0, scc_pkg::CMD_ADD, 1, 1, 0, 0},
    '{0, scc_pkg::CMD_COMPUTE, 0, 0, 1, 1},
    '{0, scc_pkg::CMD_QUERY, 1, 0, 1, 1}
  };

  function automatic int unsigned live_nodes();
    return (model_nodes > NMAX) ? NMAX : model_nodes;
  endfunction

  function automatic void store_edge(int unsigned s, int unsigned d);
    int unsigned n;
    n = live_nodes();
    if (s < 1 || s > n || d < 1 || d > n) return;
    if (n_edges >= EMAX) begin
      dropped = 1'b1;
      return;
    end
    dst_e[n_edges] = d;
    link_o[n_edges] = 0;
    if (tail_o[s] != 0) link_o[tail_o[s]-1] = n_edges + 1;
    else head_o[s] = n_edges + 1;
    tail_o[s] = n_edges + 1;
    n_edges++;
  endfunction

  function automatic void label_components();
    int unsigned n, fin, sp, top, p, d, k, cnt, u, v, w;
    n = live_nodes();
    fin = 0;
    seen = '{default: 0};
    for (int s = 1; s <= n; s++) begin
      if (!seen[s]) begin
        seen[s] = 1;
        stk_n[0] = s;
        stk_p[0] = head_o[s];
        sp = 1;
        while (sp > 0) begin
          top = sp - 1;
          p = stk_p[top];
          if (p == 0) begin
            fin_ord[fin] = stk_n[top];
            fin++;
            sp--;
          end else begin
            stk_p[top] = link_o[p-1];
            d = dst_e[p-1];
            if (d >= 1 && d <= n && !seen[d]) begin
              seen[d] = 1;
              stk_n[sp] = d;
              stk_p[sp] = head_o[d];
              sp++;
            end
          end
        end
      end
    end
    head_i = '{default: 0};
    tail_i = '{default: 0};
    k = 0;
    for (int i = 1; i <= n; i++) begin
      p = head_o[i];
      while (p != 0) begin
        d = dst_e[p-1];
        if (d >= 1 && d <= n) begin
          src_i[k] = i;
          link_i[k] = 0;
          if (tail_i[d] != 0) link_i[tail_i[d]-1] = k + 1;
          else head_i[d] = k + 1;
          tail_i[d] = k + 1;
          k++;
        end
        p = link_o[p-1];
      end
    end
    seen = '{default: 0};
    label = '{default: 0};
    cnt = 0;
    for (int f = fin; f > 0; f--) begin
      u = fin_ord[f-1];
      if (!seen[u]) begin
        cnt++;
        seen[u] = 1;
        label[u] = cnt;
        stk_n[0] = u;
        sp = 1;
        while (sp > 0) begin
          sp--;
          v = stk_n[sp];
          p = head_i[v];
          while (p != 0) begin
            w = src_i[p-1];
            if (!seen[w]) begin
              seen[w] = 1;
              label[w] = cnt;
              stk_n[sp] = w;
              sp++;
            end
            p = link_i[p-1];
          end
        end
      end
    end
    n_comp = cnt & 11'h7FF;
  endfunction

  function automatic void predict(logic [1:0] cmd, int unsigned s, int unsigned d,
                                  bit typed, int val);
    scc_pkg::scc_result_t r;
    r.edges_dropped = 1'b0;
    r.value = '0;
    case (cmd)
      scc_pkg::CMD_ADD: begin
        store_edge(s, d);
        return;
      end
      scc_pkg::CMD_COMPUTE: begin
        label_components();
        r.value = n_comp[scc_pkg::PORT_W-1:0];
      end
      scc_pkg::CMD_QUERY: begin
        if (s >= 1 && s <= live_nodes()) r.value = label[s][scc_pkg::PORT_W-1:0];
      end
      default: return;
    endcase
    r.edges_dropped = dropped;
    if (typed) r.value = val[scc_pkg::PORT_W-1:0];
    pending_rsp = {pending_rsp, r};
  endfunction

  task automatic send(logic [1:0] cmd, int unsigned s, int unsigned d,
                      bit typed = 0, int val = 0);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    req.valid <= 1'b1;
    req.command <= cmd;
    req.source_node <= s[scc_pkg::PORT_W-1:0];
    req.target_node <= d[scc_pkg::PORT_W-1:0];
    do @(posedge clk); while (!req.ready);
    predict(cmd, s & 11'h7FF, d & 11'h7FF, typed, val);
    burst_left--;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    burst_left = 0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_node_count(int unsigned n);
    drain();
    cfg.valid <= 1'b1;
    cfg.data <= n[scc_pkg::PORT_W-1:0];
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    model_nodes = n & 11'h7FF;
  endtask

  function automatic int unsigned pick_node(int unsigned n);
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 2047);
    return $urandom_range(1, n);
  endfunction

  task automatic random_phase();
    int unsigned n, len, sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) n = 1;
    else if (sel == 1) n = 1024;
    else if (sel == 2) n = 2047;
    else if (sel == 3) n = 0;
    else n = $urandom_range(2, 40);
    write_node_count(n);
    if (n == 0) n = 1;
    if (n > NMAX) n = NMAX;
    len = $urandom_range(10, 60);
    repeat (len) begin
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        send(scc_pkg::CMD_ADD, pick_node(n), pick_node(n));
      end else if (sel < 88) begin
        send(scc_pkg::CMD_QUERY, pick_node(n), $urandom_range(0, 2047));
      end else if (sel < 90) begin
        send(CMD_UNUSED, $urandom_range(0, 2047), $urandom_range(0, 2047));
      end else if (sel < 92) begin
        send(scc_pkg::CMD_COMPUTE, $urandom_range(0, 2047), $urandom_range(0, 2047));
      end else begin
        send(scc_pkg::CMD_ADD, $urandom_range(0, 2047), $urandom_range(0, 2047));
      end
      items_sent++;
    end
    send(scc_pkg::CMD_COMPUTE, $urandom_range(0, 2047), $urandom_range(0, 2047));
    len = $urandom_range(4, 20);
    repeat (len) begin
      send(scc_pkg::CMD_QUERY, pick_node(n), $urandom_range(0, 2047));
      items_sent++;
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles % 200 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: rsp.ready <= 1'b1;
      1: rsp.ready <= $urandom_range(0, 1);
      default: rsp.ready <= ($urandom_range(0, 5) == 0);
    endcase
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    scc_pkg::scc_result_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response value=%0d dropped=%0b", $time,
                 rsp.value, rsp.edges_dropped);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.value !== e.value) begin
          $display("%0t: value expected %0d actual %0d", $time, e.value, rsp.value);
          errors++;
        end
        if (rsp.edges_dropped !== e.edges_dropped) begin
          $display("%0t: edges_dropped expected %0b actual %0b", $time,
                   e.edges_dropped, rsp.edges_dropped);
          errors++;
        end
      end
    end
  end

  initial begin
    req.valid = 1'b0;
    req.command = scc_pkg::CMD_ADD;
    req.source_node = '0;
    req.target_node = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    rsp.ready = 1'b0;
    model_nodes = scc_pkg::NODE_COUNT_RESET;
    n_edges = 0;
    n_comp = 0;
    dropped = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_node_count(plan[i].src);
      else send(plan[i].cmd, plan[i].src, plan[i].dst, plan[i].typed, plan[i].val);
    end

    while (items_sent < RANDOM_ITEMS) random_phase();

    // Shrink the node count below stored edges and label again.
    write_node_count(6);
    send(scc_pkg::CMD_COMPUTE, 0, 0);
    repeat (6) send(scc_pkg::CMD_QUERY, $urandom_range(0, 7), 0);

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/scc_pkg.sv
rtl/scc_req_if.sv
rtl/scc_rsp_if.sv
rtl/scc_cfg_if.sv
rtl/scc_engine.sv
rtl/strongly_connected_component_labeler_core.sv
verif/tb.sv
